// ===== rtl/bdeq_pkg.sv =====
// ---------------------------------------------------------------------------
// bdeq_pkg
// Shared types and constants for the bounded double-ended queue.
// ---------------------------------------------------------------------------
package bdeq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int OP_W          = 3;
    localparam int CAP_W         = 5;

    localparam logic [CAP_W-1:0]  CAP_RESET   = 5'd16;
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;

    typedef struct packed {
        logic load;
        logic exec;
        logic fetch;
    } bdeq_cmd_t;

endpackage

// ===== rtl/bdeq_ctrl.sv =====
// ---------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer: accept a beat, execute it, fetch both ends, present the result.
// ---------------------------------------------------------------------------
module bdeq_ctrl
    import bdeq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output bdeq_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FETCH,
        S_DONE
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                S_EXEC:
                begin
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    state_reg <= S_DONE;
                    done_reg  <= 1'b1;
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                    done_reg  <= 1'b0;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign cmd.load  = start && !busy_reg;
    assign cmd.exec  = (state_reg == S_EXEC);
    assign cmd.fetch = (state_reg == S_FETCH);

endmodule

// ===== rtl/bdeq_dp.sv =====
// ---------------------------------------------------------------------------
// bdeq_dp
// Ring buffer datapath: slot memory, head index, count and capacity limit.
// ---------------------------------------------------------------------------
module bdeq_dp
    import bdeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bdeq_cmd_t                cmd,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    output logic                     ok,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] rear_value,
    output logic                     empty_res,
    output logic                     full_res
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [DATA_W-1:0] mem [DEPTH];

    logic [OP_W-1:0]   op_reg;
    logic [DATA_W-1:0] value_reg;
    logic [IDX_W-1:0]  head_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CAP_W-1:0]  cap_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] front_reg;
    logic [DATA_W-1:0] rear_reg;

    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_next;
    logic              ok_next;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;

    logic [LIM_W-1:0]  lim;
    logic              full;
    logic              empty;
    logic [SUM_W-1:0]  sum;
    logic [IDX_W-1:0]  tail;
    logic [IDX_W-1:0]  rear_idx;
    logic [IDX_W-1:0]  head_dec;
    logic [IDX_W-1:0]  head_inc;

    always_comb
    begin
        lim = (LIM_W'(cap_reg) > LIM_W'(DEPTH)) ? LIM_W'(DEPTH) : LIM_W'(cap_reg);
    end

    assign full  = (LIM_W'(count_reg) >= lim);
    assign empty = (count_reg == '0);

    assign sum      = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail     = (sum >= SUM_W'(DEPTH)) ? IDX_W'(sum - SUM_W'(DEPTH)) : IDX_W'(sum);
    assign rear_idx = (tail == '0) ? IDX_W'(DEPTH - 1) : tail - 1'b1;
    assign head_dec = (head_reg == '0) ? IDX_W'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        ok_next    = 1'b1;
        mem_we     = 1'b0;
        mem_waddr  = tail;
        unique case (op_reg)
            OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next  = head_dec;
                    mem_we     = 1'b1;
                    mem_waddr  = head_dec;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (full)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    head_next  = head_inc;
                    count_next = count_reg - 1'b1;
                end
            end
            OP_POP_BACK:
            begin
                if (empty)
                begin
                    ok_next = 1'b0;
                end
                else
                begin
                    count_next = count_reg - 1'b1;
                end
            end
            default:
            begin
                ok_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            cap_reg   <= CAP_RESET;
            ok_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                head_reg  <= head_next;
                count_reg <= count_next;
                ok_reg    <= ok_next;
            end
        end
    end

    // hold the accepted beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg    <= operation;
            value_reg <= value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[mem_waddr] <= value_reg;
        end
        if (cmd.fetch)
        begin
            front_reg <= mem[head_reg];
            rear_reg  <= mem[rear_idx];
        end
    end

    assign ok          = ok_reg;
    assign empty_res   = empty;
    assign full_res    = full;
    assign front_value = empty ? EMPTY_VALUE : front_reg;
    assign rear_value  = empty ? EMPTY_VALUE : rear_reg;

endmodule

// ===== rtl/bounded_double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// bounded_double_ended_queue
// Ring-buffer deque of signed 32-bit values with a configurable capacity.
// done strobes after the execute and fetch states, for one cycle.
// A new beat is taken only from idle, so each beat runs the execute/fetch/present
// sequence around the single-write slot memory before the next is accepted.
// Reset: empty deque, head at slot 0, capacity 16; slot contents undefined.
// The receiver cannot stall; each result is valid only while done is high.
// ---------------------------------------------------------------------------
module bounded_double_ended_queue
    import bdeq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          operation,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     cfg_we,
    input  logic [CAP_W-1:0]         cfg_wdata,
    output logic                     done,
    output logic                     ok,
    output logic signed [DATA_W-1:0] front_value,
    output logic signed [DATA_W-1:0] rear_value,
    output logic                     empty_res,
    output logic                     full_res
);

    bdeq_cmd_t cmd;

    bdeq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    bdeq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .operation   (operation),
        .value       (value),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .ok          (ok),
        .front_value (front_value),
        .rear_value  (rear_value),
        .empty_res   (empty_res),
        .full_res    (full_res)
    );

`ifndef NO_ASSERTIONS
    a_done_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done outside busy window");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one beat");

    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("result not presented three cycles after accept");
`endif

endmodule
